// ----- rtl/eost_pkg.sv -----
// Package for the expiry-ordered server table.
// Holds the result codes, controller states and the command and status structs.
// It depends on nothing else.
package eost_pkg;

   localparam int TIME_W = 32;
   localparam int ADDR_W = 64;
   localparam int KIND_W = 2;
   localparam int STATUS_W = 3;
   localparam int POS_W = 2;
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 168;

   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

   localparam logic [STATUS_W-1:0] STS_REFRESHED = 3'd0;
   localparam logic [STATUS_W-1:0] STS_ADDED = 3'd1;
   localparam logic [STATUS_W-1:0] STS_REPLACED = 3'd2;
   localparam logic [STATUS_W-1:0] STS_EXPIRED = 3'd3;
   localparam logic [STATUS_W-1:0] STS_DROPPED = 3'd4;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_MATCH = 8'b0000_0010,
      S_DECIDE = 8'b0000_0100,
      S_PLACE = 8'b0000_1000,
      S_WRITE = 8'b0001_0000,
      S_RESP = 8'b0010_0000,
      S_TRIM = 8'b0100_0000,
      S_LIST = 8'b1000_0000
   } eost_state_type;

   typedef struct packed {
      logic latch;
      logic match;
      logic decide;
      logic place;
      logic write;
      logic trim_dec;
      logic list_clear;
      logic list_rd;
      logic emit_status;
      logic emit_entry;
      logic emit_empty;
   } eost_cmd_type;

   typedef struct packed {
      logic will_write;
      logic tail_expired;
      logic count_zero;
      logic list_last;
      logic rsp_free;
   } eost_sts_type;

endpackage

// ----- rtl/eost_dp.sv -----
// Datapath of the expiry-ordered server table: entry registers, match, ordered insertion,
// trim and list read, and the result word register.
// Depends on eost_pkg.
module eost_dp
   import eost_pkg::*;
#(
   parameter int TABLE_ENTRIES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  eost_cmd_type          cmd,
   output eost_sts_type          sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

   logic [ADDR_W-1:0] addr_hi_ff [TABLE_ENTRIES];
   logic [ADDR_W-1:0] addr_lo_ff [TABLE_ENTRIES];
   logic [TIME_W-1:0] exp_ff [TABLE_ENTRIES];
   logic [CNT_W-1:0] count_ff, count_in;

   logic [TIME_W-1:0] now_ff;
   logic [ADDR_W-1:0] upd_hi_ff;
   logic [ADDR_W-1:0] upd_lo_ff;
   logic [TIME_W-1:0] upd_exp_ff;

   logic hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic hit_in;
   logic [IDX_W-1:0] hit_idx_in;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0] tgt_ff, tgt_in;
   logic dec_inc;
   logic [IDX_W-1:0] place_ff;
   logic [CNT_W-1:0] place_in;

   logic [IDX_W-1:0] list_idx_ff, list_idx_in;
   logic [CNT_W-1:0] cnt_m1;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W+POS_W-1:0] pos_ext;

   logic will_write;
   logic tail_expired;
   logic count_zero;
   logic list_last;
   logic rsp_free;

   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [KIND_W-1:0] rsp_tuser_ff, rsp_tuser_in;
   logic rsp_tlast_ff, rsp_tlast_in;
   logic load_rsp;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         now_ff <= req_tdata[31:0];
         upd_hi_ff <= req_tdata[95:32];
         upd_lo_ff <= req_tdata[159:96];
         upd_exp_ff <= req_tdata[191:160];
      end
   end

   always_comb begin
      hit_in = 1'b0;
      hit_idx_in = '0;
      for (int j = TABLE_ENTRIES - 1; j >= 0; j--) begin
         if (CNT_W'(j) < count_ff && addr_hi_ff[j] == upd_hi_ff
               && addr_lo_ff[j] == upd_lo_ff) begin
            hit_in = 1'b1;
            hit_idx_in = IDX_W'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         hit_ff <= hit_in;
         hit_idx_ff <= hit_idx_in;
      end
   end

   always_comb begin
      will_write = 1'b1;
      status_in = STS_REFRESHED;
      tgt_in = hit_idx_ff;
      dec_inc = 1'b0;
      if (!hit_ff) begin
         if (upd_exp_ff == now_ff) begin
            status_in = STS_EXPIRED;
            will_write = 1'b0;
         end else if (count_ff < FULL_CNT) begin
            status_in = STS_ADDED;
            tgt_in = count_ff[IDX_W-1:0];
            dec_inc = 1'b1;
         end else if (upd_exp_ff >= exp_ff[TABLE_ENTRIES-1]) begin
            status_in = STS_REPLACED;
            tgt_in = IDX_W'(TABLE_ENTRIES - 1);
         end else begin
            status_in = STS_DROPPED;
            will_write = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         status_ff <= status_in;
         tgt_ff <= tgt_in;
      end
   end

   always_comb begin
      place_in = '0;
      for (int j = 0; j < TABLE_ENTRIES; j++) begin
         if (CNT_W'(j) < count_ff && IDX_W'(j) != tgt_ff
               && (exp_ff[j] > upd_exp_ff
                   || (exp_ff[j] == upd_exp_ff && IDX_W'(j) < tgt_ff))) begin
            place_in = place_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         place_ff <= place_in[IDX_W-1:0];
      end
   end

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_entry
      localparam int UP = (g < TABLE_ENTRIES - 1) ? g + 1 : g;
      localparam int DN = (g > 0) ? g - 1 : g;
      localparam logic [IDX_W-1:0] GI = IDX_W'(g);

      always_ff @(posedge clock) begin
         if (cmd.write) begin
            if (GI < place_ff) begin
               if (GI >= tgt_ff) begin
                  addr_hi_ff[g] <= addr_hi_ff[UP];
                  addr_lo_ff[g] <= addr_lo_ff[UP];
                  exp_ff[g] <= exp_ff[UP];
               end
            end else if (GI == place_ff) begin
               addr_hi_ff[g] <= upd_hi_ff;
               addr_lo_ff[g] <= upd_lo_ff;
               exp_ff[g] <= upd_exp_ff;
            end else if (GI <= tgt_ff) begin
               addr_hi_ff[g] <= addr_hi_ff[DN];
               addr_lo_ff[g] <= addr_lo_ff[DN];
               exp_ff[g] <= exp_ff[DN];
            end
         end
      end
   end

   assign cnt_m1 = count_ff - 1'b1;
   assign rd_idx = cmd.list_rd ? list_idx_ff : cnt_m1[IDX_W-1:0];
   assign pos_ext = {{POS_W{1'b0}}, list_idx_ff};

   always_comb begin
      count_in = count_ff;
      if (cmd.decide && dec_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.trim_dec) begin
         count_in = cnt_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      list_idx_in = list_idx_ff;
      if (cmd.list_clear) begin
         list_idx_in = '0;
      end else if (cmd.emit_entry) begin
         list_idx_in = list_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_idx_ff <= '0;
      end else begin
         list_idx_ff <= list_idx_in;
      end
   end

   assign count_zero = (count_ff == '0);
   assign tail_expired = (count_ff != '0) && (exp_ff[rd_idx] <= now_ff);
   assign list_last = ((CNT_W'(list_idx_ff) + 1'b1) == count_ff);
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   assign sts = {will_write, tail_expired, count_zero, list_last, rsp_free};

   assign load_rsp = cmd.emit_status || cmd.emit_entry || cmd.emit_empty;

   always_comb begin
      rsp_tdata_in = '0;
      rsp_tuser_in = KIND_EMPTY;
      rsp_tlast_in = 1'b1;
      if (cmd.emit_status) begin
         rsp_tuser_in = KIND_STATUS;
         rsp_tdata_in[2:0] = status_ff;
      end else if (cmd.emit_entry) begin
         rsp_tuser_in = KIND_ENTRY;
         rsp_tlast_in = list_last;
         rsp_tdata_in = {3'b000, exp_ff[rd_idx], addr_lo_ff[rd_idx], addr_hi_ff[rd_idx],
                         pos_ext[POS_W-1:0], 3'b000};
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (load_rsp) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
         rsp_tlast_ff <= rsp_tlast_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;
   assign rsp_tlast = rsp_tlast_ff;

endmodule

// ----- rtl/eost_ctrl.sv -----
// Controller state machine of the expiry-ordered server table.
// Sequences the datapath through commands and reads back its status; depends on eost_pkg.
module eost_ctrl
   import eost_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,
   input  eost_sts_type sts,
   output eost_cmd_type cmd
);

   eost_state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in = req_tuser ? S_TRIM : S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.match = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = sts.will_write ? S_PLACE : S_RESP;
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.emit_status = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_TRIM: begin
            if (sts.tail_expired) begin
               cmd.trim_dec = 1'b1;
            end else begin
               cmd.list_clear = 1'b1;
               state_in = S_LIST;
            end
         end
         S_LIST: begin
            cmd.list_rd = 1'b1;
            if (sts.rsp_free) begin
               if (sts.count_zero) begin
                  cmd.emit_empty = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.emit_entry = 1'b1;
                  if (sts.list_last) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/expiry_ordered_server_table_top.sv -----
// Top level of the expiry-ordered server table.
// Joins the controller eost_ctrl and the datapath eost_dp; depends on eost_pkg.
//
// The table holds up to TABLE_ENTRIES server addresses with expiry times, latest expiry
// first. An update word (tuser 0) that changes the table passes through match, decide,
// find the insertion place, shift and write, and send the status word, then returns to
// idle, which accepts the next word; when the address is ignored or dropped, it goes
// from decide straight to sending the status word. A refresh word (tuser 1) trims
// expired entries from the tail one at a time, starts the list, sends each listed entry
// or the empty-list word, and returns to idle, which accepts the next word. The
// controller handles one word at a time; a waiting result word only stalls the block
// when the next result has to be sent.
module expiry_ordered_server_table_top
   import eost_pkg::*;
#(
   parameter int TABLE_ENTRIES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now[31:0], address_hi[95:32], address_lo[159:96], expiry[191:160]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[2:0], position[4:3], out_address_hi[68:5], out_address_lo[132:69],
   // out_expiry[164:133], zero fill[167:165]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // kind[1:0]
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   eost_cmd_type cmd;
   eost_sts_type sts;

   eost_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   eost_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
